### hdl/gyro_quaternion_integrator_assert.svh
// Assertion macros shared by the gyro quaternion integrator RTL.
// Define ASSERT_OFF to compile every check out.
`ifndef GYRO_QUATERNION_INTEGRATOR_ASSERT_SVH
`define GYRO_QUATERNION_INTEGRATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define GQI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gqi assertion failed");
// Check that a condition never holds outside reset.
`define GQI_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("gqi forbidden condition seen");
`else
`define GQI_ASSERT(lbl, clk, rst_n, prop)
`define GQI_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### hdl/gqi_pkg.sv
// Types, constants and the Hamilton product term table of the gyro integrator.
// No dependencies; used by gqi_ctrl, gqi_datapath and the top level.
package gqi_pkg;

  // Opcodes of an input word
  localparam logic [1:0] OP_INTEG    = 2'd0;
  localparam logic [1:0] OP_LOAD_INT = 2'd1;
  localparam logic [1:0] OP_LOAD     = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  // Configuration register indexes
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_STEP = 1'b1;

  localparam int CFG_W = 24;

  localparam logic signed [31:0] ONE_Q30    = 32'sh4000_0000;
  localparam logic [23:0]        STEP_RESET = 24'd16777;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [23:0] rate_x;
    logic signed [23:0] rate_y;
    logic signed [23:0] rate_z;
    logic signed [31:0] load_w;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               norm_was_zero;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_DQ_MUL, S_DQ_ACC, S_DQ_FIN, S_INC_MH, S_INC_AH, S_INC_AL,
    S_INC_FIN, S_ORP, S_ZCHK, S_LZ, S_SHF, S_SQM, S_SQA, S_SQRT_INIT, S_SQRT,
    S_DIV_INIT, S_DIV, S_DIV_FIN, S_DONE
  } state_t;

  typedef enum logic [1:0] {MUL_RATE, MUL_STH, MUL_STL, MUL_SQ} mul_sel_t;

  typedef enum logic [2:0] {ACC_HOLD, ACC_CLEAR, ACC_ADD, ACC_SUB, ACC_ADD_SH16} acc_op_t;

  typedef struct packed {
    logic [1:0] qidx;
    logic [1:0] ridx;
    logic       neg;
  } term_t;

  typedef struct packed {
    logic       load_q;
    mul_sel_t   mul_sel;
    logic       mul_en;
    acc_op_t    acc_op;
    logic [1:0] comp;
    logic [1:0] term;
    logic       dq_fin;
    logic       p_fin;
    logic       or_acc;
    logic       set_ident;
    logic       zflag_clr;
    logic       lz_init;
    logic       lz_step;
    logic       len_set;
    logic       shf;
    logic       sq_clr;
    logic       sq_add;
    logic       sqrt_init;
    logic       sqrt_step;
    logic [4:0] iter;
    logic       div_init;
    logic       div_step;
    logic       div_fin;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic mor_zero;
    logic lz_top_zero;
    logic out_free;
  } status_t;

  // Terms of q (x) (0, v): quaternion index, rate index, subtract
  function automatic term_t dq_term(logic [1:0] comp, logic [1:0] term);
    term_t t;
    t = '0;
    unique case ({comp, term})
      4'h0: t = '{qidx: 2'd1, ridx: 2'd0, neg: 1'b1};
      4'h1: t = '{qidx: 2'd2, ridx: 2'd1, neg: 1'b1};
      4'h2: t = '{qidx: 2'd3, ridx: 2'd2, neg: 1'b1};
      4'h4: t = '{qidx: 2'd0, ridx: 2'd0, neg: 1'b0};
      4'h5: t = '{qidx: 2'd2, ridx: 2'd2, neg: 1'b0};
      4'h6: t = '{qidx: 2'd3, ridx: 2'd1, neg: 1'b1};
      4'h8: t = '{qidx: 2'd0, ridx: 2'd1, neg: 1'b0};
      4'h9: t = '{qidx: 2'd1, ridx: 2'd2, neg: 1'b1};
      4'hA: t = '{qidx: 2'd3, ridx: 2'd0, neg: 1'b0};
      4'hC: t = '{qidx: 2'd0, ridx: 2'd2, neg: 1'b0};
      4'hD: t = '{qidx: 2'd1, ridx: 2'd1, neg: 1'b0};
      4'hE: t = '{qidx: 2'd2, ridx: 2'd0, neg: 1'b1};
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

### hdl/gqi_datapath.sv
// Datapath of the gyro integrator: state, shared multiplier, accumulator,
// normalizer, square root and divider. Uses gqi_pkg; driven by gqi_ctrl.
module gqi_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gqi_pkg::in_word_t      in_data,
  input  logic                   in_capture,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [gqi_pkg::CFG_W-1:0] cfg_wdata,
  input  gqi_pkg::cmd_t          cmd,
  output gqi_pkg::status_t       stat,
  input  logic                   out_stall,
  output logic                   out_valid,
  output gqi_pkg::out_word_t     out_data
);

  gqi_pkg::in_word_t  in_r;
  logic signed [31:0] q_r [4];
  logic signed [39:0] prev_r [4];
  logic               mode_r;
  logic [23:0]        st_r;
  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r;
  logic signed [40:0] s_r;
  logic signed [63:0] p_r [4];
  logic [63:0]        mor_r;
  logic [63:0]        lz_r;
  logic [4:0]         lzc_r;
  logic [6:0]         len_r;
  logic signed [31:0] r_r [4];
  logic [62:0]        sq_r;
  logic [62:0]        v_r;
  logic [63:0]        res_r;
  logic [31:0]        n_r;
  logic [31:0]        rem_r;
  logic [31:0]        dlo_r;
  logic [31:0]        quo_r;
  logic               zflag_r;
  logic               out_valid_r;
  gqi_pkg::out_word_t out_r;

  gqi_pkg::term_t     term;
  logic [1:0]         q_addr;
  logic signed [31:0] q_rd;
  logic signed [23:0] rate_v [3];
  logic signed [31:0] mul_a, mul_b;
  logic signed [65:0] dq_rnd;
  logic signed [39:0] dq;
  logic signed [65:0] inc_rnd, inc;
  logic signed [63:0] p_sel;
  logic [63:0]        p_abs;
  logic [6:0]         k;
  logic [63:0]        half_k;
  logic signed [63:0] rsh, lsh;
  logic [1:0]         nlz;
  logic [63:0]        bitv, trial;
  logic signed [31:0] r_sel;
  logic [31:0]        r_abs;
  logic [31:0]        n_v;
  logic [61:0]        dvd;
  logic [32:0]        rem2;
  logic               ge;

  // Operand selection
  always_comb begin
    term   = gqi_pkg::dq_term(cmd.comp, cmd.term);
    q_addr = (cmd.mul_sel == gqi_pkg::MUL_RATE) ? term.qidx : cmd.comp;
    q_rd   = q_r[q_addr];
    rate_v[0] = in_r.rate_x;
    rate_v[1] = in_r.rate_y;
    rate_v[2] = in_r.rate_z;
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      gqi_pkg::MUL_RATE: begin
        mul_a = q_rd;
        mul_b = {{8{rate_v[term.ridx][23]}}, rate_v[term.ridx]};
      end
      gqi_pkg::MUL_STH: begin
        mul_a = {{7{s_r[40]}}, s_r[40:16]};
        mul_b = {8'd0, st_r};
      end
      gqi_pkg::MUL_STL: begin
        mul_a = {16'd0, s_r[15:0]};
        mul_b = {8'd0, st_r};
      end
      gqi_pkg::MUL_SQ: begin
        mul_a = r_r[cmd.comp];
        mul_b = r_r[cmd.comp];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Rounding, normalizing shift, square root and divider steps
  always_comb begin
    dq_rnd  = acc_r + 66'sd131072;
    dq      = dq_rnd[57:18];
    inc_rnd = acc_r + (mode_r ? 66'sd128 : 66'sd64);
    inc     = mode_r ? (inc_rnd >>> 8) : (inc_rnd >>> 7);
    p_sel   = p_r[cmd.comp];
    p_abs   = p_sel[63] ? (64'd0 - p_sel) : p_sel;
    k       = len_r - 7'd30;
    half_k  = 64'd1 << (k - 7'd1);
    rsh     = $signed(p_sel + half_k) >>> k;
    lsh     = p_sel <<< (7'd30 - len_r);
    nlz     = lz_r[63] ? 2'd0 : lz_r[62] ? 2'd1 : lz_r[61] ? 2'd2 : 2'd3;
    bitv    = 64'd1 << (7'd62 - {1'b0, cmd.iter, 1'b0});
    trial   = res_r + bitv;
    r_sel   = r_r[cmd.comp];
    r_abs   = r_sel[31] ? (32'd0 - r_sel) : r_sel;
    n_v     = (res_r == 64'd0) ? 32'd1 : res_r[31:0];
    dvd     = {1'b0, r_abs[30:0], 30'd0} + {31'd0, n_v[31:1]};
    rem2    = {rem_r, dlo_r[31]};
    ge      = rem2 >= {1'b0, n_r};
  end

  // Configuration and orientation state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      st_r   <= gqi_pkg::STEP_RESET;
      q_r[0] <= gqi_pkg::ONE_Q30;
      q_r[1] <= '0;
      q_r[2] <= '0;
      q_r[3] <= '0;
      for (int i = 0; i < 4; i++) begin
        prev_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gqi_pkg::REG_MODE: mode_r <= cfg_wdata[0];
          gqi_pkg::REG_STEP: st_r   <= cfg_wdata[23:0];
          default: ;
        endcase
      end
      if (cmd.load_q) begin
        q_r[0] <= in_r.load_w;
        q_r[1] <= in_r.load_x;
        q_r[2] <= in_r.load_y;
        q_r[3] <= in_r.load_z;
      end else if (cmd.set_ident) begin
        q_r[0] <= gqi_pkg::ONE_Q30;
        q_r[1] <= '0;
        q_r[2] <= '0;
        q_r[3] <= '0;
      end else if (cmd.div_fin) begin
        q_r[cmd.comp] <= r_sel[31] ? (32'd0 - quo_r) : quo_r;
      end
      if (cmd.dq_fin) begin
        prev_r[cmd.comp] <= dq;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (in_capture) begin
      in_r <= in_data;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    unique case (cmd.acc_op)
      gqi_pkg::ACC_HOLD:     acc_r <= acc_r;
      gqi_pkg::ACC_CLEAR:    acc_r <= '0;
      gqi_pkg::ACC_ADD:      acc_r <= acc_r + {{2{prod_r[63]}}, prod_r};
      gqi_pkg::ACC_SUB:      acc_r <= acc_r - {{2{prod_r[63]}}, prod_r};
      gqi_pkg::ACC_ADD_SH16: acc_r <= acc_r + $signed({prod_r[49:0], 16'd0});
      default:               acc_r <= acc_r;
    endcase
    if (cmd.dq_fin) begin
      s_r <= mode_r ? ($signed({dq[39], dq}) + $signed({prev_r[cmd.comp][39],
                                                         prev_r[cmd.comp]}))
                    : $signed({dq[39], dq});
    end
    // p = q * 2^16 + rounded increment
    if (cmd.p_fin) begin
      p_r[cmd.comp] <= $signed({{16{q_rd[31]}}, q_rd, 16'd0}) + inc[63:0];
    end
    if (cmd.or_acc) begin
      mor_r <= ((cmd.comp == 2'd0) ? 64'd0 : mor_r) | p_abs;
    end
    // Leading-zero search, one nibble a cycle
    if (cmd.lz_init) begin
      lz_r  <= mor_r;
      lzc_r <= '0;
    end else if (cmd.lz_step) begin
      lz_r  <= lz_r << 4;
      lzc_r <= lzc_r + 5'd1;
    end
    if (cmd.len_set) begin
      len_r <= 7'd64 - {lzc_r, 2'b00} - {5'd0, nlz};
    end
    if (cmd.shf) begin
      r_r[cmd.comp] <= (len_r > 7'd30) ? rsh[31:0] : lsh[31:0];
    end
    if (cmd.sq_clr) begin
      sq_r <= '0;
    end else if (cmd.sq_add) begin
      sq_r <= sq_r + prod_r[62:0];
    end
    // Integer square root, one bit of the root a cycle
    if (cmd.sqrt_init) begin
      v_r   <= sq_r;
      res_r <= '0;
    end else if (cmd.sqrt_step) begin
      if ({1'b0, v_r} >= trial) begin
        v_r   <= v_r - trial[62:0];
        res_r <= (res_r >> 1) + bitv;
      end else begin
        res_r <= res_r >> 1;
      end
    end
    // Restoring division, one quotient bit a cycle
    if (cmd.div_init) begin
      n_r   <= n_v;
      rem_r <= {2'd0, dvd[61:32]};
      dlo_r <= dvd[31:0];
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? 32'(rem2 - {1'b0, n_r}) : rem2[31:0];
      quo_r <= {quo_r[30:0], ge};
      dlo_r <= dlo_r << 1;
    end
    if (cmd.set_ident) begin
      zflag_r <= 1'b1;
    end else if (cmd.zflag_clr) begin
      zflag_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_r <= '{quat_w: q_r[0], quat_x: q_r[1], quat_y: q_r[2], quat_z: q_r[3],
                 norm_was_zero: zflag_r};
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_r;
  assign stat.mor_zero    = (mor_r == 64'd0);
  assign stat.lz_top_zero = (lz_r[63:60] == 4'd0);
  assign stat.out_free    = !out_valid_r || !out_stall;

endmodule

### hdl/gqi_ctrl.sv
// Sequencer of the gyro integrator: walks each word through the datapath.
// Uses gqi_pkg and the assertion macros; commands gqi_datapath.
`include "gyro_quaternion_integrator_assert.svh"
module gqi_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_opcode,
  output logic             in_stall,
  output logic             in_capture,
  input  gqi_pkg::status_t stat,
  output gqi_pkg::cmd_t    cmd
);

  gqi_pkg::state_t state_r, state_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [1:0]      ci_r, ci_nxt;
  logic [1:0]      ct_r, ct_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  gqi_pkg::term_t  term;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gqi_pkg::S_IDLE;
      op_r    <= gqi_pkg::OP_INTEG;
      ci_r    <= '0;
      ct_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      ci_r    <= ci_nxt;
      ct_r    <= ct_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    ci_nxt      = ci_r;
    ct_nxt      = ct_r;
    cnt_nxt     = cnt_r;
    term        = gqi_pkg::dq_term(ci_r, ct_r);
    in_stall    = 1'b1;
    in_capture  = 1'b0;
    cmd         = '0;
    cmd.mul_sel = gqi_pkg::MUL_SQ;
    cmd.acc_op  = gqi_pkg::ACC_HOLD;
    cmd.comp    = ci_r;
    cmd.term    = ct_r;
    cmd.iter    = cnt_r;
    unique case (state_r)
      gqi_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          in_capture = 1'b1;
          op_nxt     = in_opcode;
          ci_nxt     = '0;
          ct_nxt     = '0;
          unique case (in_opcode)
            gqi_pkg::OP_INTEG:    state_nxt = gqi_pkg::S_DQ_MUL;
            gqi_pkg::OP_LOAD_INT: state_nxt = gqi_pkg::S_LOAD;
            gqi_pkg::OP_LOAD:     state_nxt = gqi_pkg::S_LOAD;
            gqi_pkg::OP_NONE:     state_nxt = gqi_pkg::S_IDLE;
            default:              state_nxt = gqi_pkg::S_IDLE;
          endcase
        end
      end
      gqi_pkg::S_LOAD: begin
        cmd.load_q    = 1'b1;
        cmd.zflag_clr = 1'b1;
        state_nxt = (op_r == gqi_pkg::OP_LOAD) ? gqi_pkg::S_DONE : gqi_pkg::S_DQ_MUL;
      end
      // Rate of change: three signed products per component
      gqi_pkg::S_DQ_MUL: begin
        cmd.mul_sel = gqi_pkg::MUL_RATE;
        cmd.mul_en  = 1'b1;
        cmd.acc_op  = (ct_r == 2'd0) ? gqi_pkg::ACC_CLEAR : gqi_pkg::ACC_HOLD;
        state_nxt   = gqi_pkg::S_DQ_ACC;
      end
      gqi_pkg::S_DQ_ACC: begin
        cmd.acc_op = term.neg ? gqi_pkg::ACC_SUB : gqi_pkg::ACC_ADD;
        if (ct_r == 2'd2) begin
          ct_nxt    = '0;
          state_nxt = gqi_pkg::S_DQ_FIN;
        end else begin
          ct_nxt    = ct_r + 2'd1;
          state_nxt = gqi_pkg::S_DQ_MUL;
        end
      end
      gqi_pkg::S_DQ_FIN: begin
        cmd.dq_fin = 1'b1;
        state_nxt  = gqi_pkg::S_INC_MH;
      end
      // Increment: step time times sum, split in two partial products
      gqi_pkg::S_INC_MH: begin
        cmd.mul_sel = gqi_pkg::MUL_STH;
        cmd.mul_en  = 1'b1;
        cmd.acc_op  = gqi_pkg::ACC_CLEAR;
        state_nxt   = gqi_pkg::S_INC_AH;
      end
      gqi_pkg::S_INC_AH: begin
        cmd.mul_sel = gqi_pkg::MUL_STL;
        cmd.mul_en  = 1'b1;
        cmd.acc_op  = gqi_pkg::ACC_ADD_SH16;
        state_nxt   = gqi_pkg::S_INC_AL;
      end
      gqi_pkg::S_INC_AL: begin
        cmd.acc_op = gqi_pkg::ACC_ADD;
        state_nxt  = gqi_pkg::S_INC_FIN;
      end
      gqi_pkg::S_INC_FIN: begin
        cmd.p_fin = 1'b1;
        state_nxt = gqi_pkg::S_ORP;
      end
      gqi_pkg::S_ORP: begin
        cmd.or_acc = 1'b1;
        if (ci_r == 2'd3) begin
          ci_nxt    = '0;
          state_nxt = gqi_pkg::S_ZCHK;
        end else begin
          ci_nxt    = ci_r + 2'd1;
          state_nxt = gqi_pkg::S_DQ_MUL;
        end
      end
      gqi_pkg::S_ZCHK: begin
        if (stat.mor_zero) begin
          cmd.set_ident = 1'b1;
          state_nxt     = gqi_pkg::S_DONE;
        end else begin
          cmd.lz_init   = 1'b1;
          cmd.zflag_clr = 1'b1;
          state_nxt     = gqi_pkg::S_LZ;
        end
      end
      gqi_pkg::S_LZ: begin
        if (stat.lz_top_zero) begin
          cmd.lz_step = 1'b1;
        end else begin
          cmd.len_set = 1'b1;
          cmd.sq_clr  = 1'b1;
          ci_nxt      = '0;
          state_nxt   = gqi_pkg::S_SHF;
        end
      end
      // Normalize each component and sum the squares
      gqi_pkg::S_SHF: begin
        cmd.shf   = 1'b1;
        state_nxt = gqi_pkg::S_SQM;
      end
      gqi_pkg::S_SQM: begin
        cmd.mul_sel = gqi_pkg::MUL_SQ;
        cmd.mul_en  = 1'b1;
        state_nxt   = gqi_pkg::S_SQA;
      end
      gqi_pkg::S_SQA: begin
        cmd.sq_add = 1'b1;
        if (ci_r == 2'd3) begin
          ci_nxt    = '0;
          state_nxt = gqi_pkg::S_SQRT_INIT;
        end else begin
          ci_nxt    = ci_r + 2'd1;
          state_nxt = gqi_pkg::S_SHF;
        end
      end
      gqi_pkg::S_SQRT_INIT: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = gqi_pkg::S_SQRT;
      end
      gqi_pkg::S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = gqi_pkg::S_DIV_INIT;
        end
      end
      // Divide each component by the norm
      gqi_pkg::S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = gqi_pkg::S_DIV;
      end
      gqi_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = gqi_pkg::S_DIV_FIN;
        end
      end
      gqi_pkg::S_DIV_FIN: begin
        cmd.div_fin = 1'b1;
        if (ci_r == 2'd3) begin
          ci_nxt    = '0;
          state_nxt = gqi_pkg::S_DONE;
        end else begin
          ci_nxt    = ci_r + 2'd1;
          state_nxt = gqi_pkg::S_DIV_INIT;
        end
      end
      // Hand the word to the output register once it is free
      gqi_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = gqi_pkg::S_IDLE;
        end
      end
      default: state_nxt = gqi_pkg::S_IDLE;
    endcase
  end

  `GQI_ASSERT(a_drop_unused, clk, rst_n, (in_valid && !in_stall && in_opcode == gqi_pkg::OP_NONE) |=> (state_r == gqi_pkg::S_IDLE))
  `GQI_ASSERT(a_div_comp_stable, clk, rst_n, (state_r == gqi_pkg::S_DIV && $past(state_r) == gqi_pkg::S_DIV) |-> $stable(ci_r))
  `GQI_ASSERT(a_done_leaves, clk, rst_n, (state_r == gqi_pkg::S_DONE && stat.out_free) |=> (state_r == gqi_pkg::S_IDLE))
  `GQI_ASSERT_NEVER(a_zchk_first_comp, clk, rst_n, state_r == gqi_pkg::S_ZCHK && ci_r != 2'd0)

endmodule

### hdl/gyro_quaternion_integrator.sv
// Gyro quaternion integrator. A load-only word passes through S_LOAD and S_DONE, then raises out_valid.
// An integrating word runs the rate products and the increment on the shared 32x32 multiplier,
// then a leading-zero search, the squares, the square root and four divisions; a zero norm
// goes from the zero check straight to the result. One word is in work at a time; the next is
// accepted once the result enters the output register, even while it waits there.
// Synchronous active-low reset restores identity orientation, zero rate history and the
// register defaults.
module gyro_quaternion_integrator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  gqi_pkg::in_word_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output gqi_pkg::out_word_t         out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [gqi_pkg::CFG_W-1:0]  cfg_wdata
);

  gqi_pkg::cmd_t    cmd;
  gqi_pkg::status_t stat;
  logic             in_capture;

  // Sequencer
  gqi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_opcode  (in_data.opcode),
    .in_stall   (in_stall),
    .in_capture (in_capture),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Arithmetic and state
  gqi_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .in_capture (in_capture),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

### tb/gqi_checker.sv
// Checker for the gyro quaternion integrator: watches the word and config ports,
// predicts every result word and compares it. Depends on gqi_pkg.
`timescale 1ns / 100ps
module gqi_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  gqi_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  gqi_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_wdata,
  output int                 errors,
  output int                 pending
);

  // Shadow orientation, rate history and registers
  logic signed [31:0] orient [4];
  longint             prev_dq [4];
  logic               trap_mode;
  logic [23:0]        step_time;
  gqi_pkg::out_word_t expected_words [$];

  assign pending = expected_words.size();

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, b, x;
    res = 0;
    x = v;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Advance the shadow state by one word and return its result
  function automatic gqi_pkg::out_word_t integrate_word(input gqi_pkg::in_word_t w);
    longint rv [3];
    longint q [4];
    longint prod [4];
    longint dq, s, inc, lo;
    longint p [4];
    longint r [4];
    longint unsigned m, a, sq, n, qv;
    int len, k, h;
    gqi_pkg::out_word_t res;
    res = '0;
    if (w.opcode != gqi_pkg::OP_INTEG) begin
      orient[0] = w.load_w; orient[1] = w.load_x;
      orient[2] = w.load_y; orient[3] = w.load_z;
    end
    if (w.opcode == gqi_pkg::OP_LOAD) begin
      res.quat_w = orient[0]; res.quat_x = orient[1];
      res.quat_y = orient[2]; res.quat_z = orient[3];
      return res;
    end
    rv[0] = longint'(w.rate_x); rv[1] = longint'(w.rate_y); rv[2] = longint'(w.rate_z);
    for (int i = 0; i < 4; i++) q[i] = longint'(orient[i]);
    // Hamilton product q (x) (0, v)
    prod[0] = -(q[1] * rv[0] + q[2] * rv[1] + q[3] * rv[2]);
    prod[1] = q[0] * rv[0] + q[2] * rv[2] - q[3] * rv[1];
    prod[2] = q[0] * rv[1] - q[1] * rv[2] + q[3] * rv[0];
    prod[3] = q[0] * rv[2] + q[1] * rv[1] - q[2] * rv[0];
    h = trap_mode ? 8 : 7;
    m = 0;
    for (int i = 0; i < 4; i++) begin
      dq = (prod[i] + (64'sd1 <<< 17)) >>> 18;
      s = trap_mode ? dq + prev_dq[i] : dq;
      lo = longint'(step_time & ((24'd1 << h) - 24'd1));
      inc = s * longint'(step_time >> h) + ((s * lo + (64'sd1 <<< (h - 1))) >>> h);
      p[i] = q[i] * 65536 + inc;
      prev_dq[i] = dq;
      a = p[i] < 0 ? longint'(-p[i]) : p[i];
      if (a > m) m = a;
    end
    // Zero norm falls back to identity
    if (m == 0) begin
      orient[0] = gqi_pkg::ONE_Q30; orient[1] = 0; orient[2] = 0; orient[3] = 0;
      res.quat_w = gqi_pkg::ONE_Q30;
      res.norm_was_zero = 1'b1;
      return res;
    end
    len = 0;
    while (len < 64 && (m >> len) != 0) len++;
    sq = 0;
    for (int i = 0; i < 4; i++) begin
      if (len > 30) begin
        k = len - 30;
        r[i] = (p[i] + (64'sd1 <<< (k - 1))) >>> k;
      end else begin
        r[i] = p[i] <<< (30 - len);
      end
      sq = sq + longint'(r[i] * r[i]);
    end
    n = root_floor(sq);
    if (n == 0) n = 1;
    for (int i = 0; i < 4; i++) begin
      a = r[i] < 0 ? longint'(-r[i]) : r[i];
      qv = ((a << 30) + (n >> 1)) / n;
      orient[i] = 32'(r[i] < 0 ? -longint'(qv) : longint'(qv));
    end
    res.quat_w = orient[0]; res.quat_x = orient[1];
    res.quat_y = orient[2]; res.quat_z = orient[3];
    return res;
  endfunction

  task automatic report_field(input string name, input longint exp_v, input longint got_v);
    errors++;
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, exp_v, got_v);
  endtask

  // Track config, predict accepted words, compare accepted results
  always @(posedge clk) begin
    gqi_pkg::out_word_t e;
    if (!rst_n) begin
      for (int i = 1; i < 4; i++) orient[i] = 0;
      orient[0] = gqi_pkg::ONE_Q30;
      for (int i = 0; i < 4; i++) prev_dq[i] = 0;
      trap_mode = 1'b0;
      step_time = gqi_pkg::STEP_RESET;
      expected_words.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == gqi_pkg::REG_MODE) trap_mode = cfg_wdata[0];
        else step_time = cfg_wdata;
      end
      if (in_valid && !in_stall && in_data.opcode != gqi_pkg::OP_NONE)
        expected_words.push_back(integrate_word(in_data));
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word %h", $time, out_data);
        end else begin
          e = expected_words.pop_front();
          if (out_data.quat_w !== e.quat_w) report_field("quat_w", e.quat_w, out_data.quat_w);
          if (out_data.quat_x !== e.quat_x) report_field("quat_x", e.quat_x, out_data.quat_x);
          if (out_data.quat_y !== e.quat_y) report_field("quat_y", e.quat_y, out_data.quat_y);
          if (out_data.quat_z !== e.quat_z) report_field("quat_z", e.quat_z, out_data.quat_z);
          if (out_data.norm_was_zero !== e.norm_was_zero)
            report_field("norm_was_zero", e.norm_was_zero, out_data.norm_was_zero);
        end
      end
    end
  end
endmodule

### tb/tb_gyro_quaternion_integrator.sv
// Top of the gyro quaternion integrator testbench: clock, reset, stimulus and verdict.
// Depends on gqi_pkg, gyro_quaternion_integrator and gqi_checker.
`timescale 1ns / 100ps
module tb_gyro_quaternion_integrator;

  localparam int DRAIN_CYCLES = 400;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  gqi_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_stall;
  gqi_pkg::out_word_t out_data;
  logic               cfg_we;
  logic               cfg_index;
  logic [23:0]        cfg_wdata;
  int                 errors;
  int                 pending;
  logic               hold_long;
  logic               no_gaps;

  gyro_quaternion_integrator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  gqi_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic signed [31:0] span(input int unsigned mag);
    return 32'(longint'($urandom_range(0, 2 * mag)) - longint'(mag));
  endfunction

  // Offer one word after a random gap, hold until accepted
  task automatic send_word(input gqi_pkg::in_word_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_fields(input logic [1:0] op, input int rx, input int ry, input int rz,
                             input int lw, input int lx, input int ly, input int lz);
    gqi_pkg::in_word_t w;
    w = '{opcode: op, rate_x: 24'(rx), rate_y: 24'(ry), rate_z: 24'(rz),
          load_w: lw, load_x: lx, load_y: ly, load_z: lz};
    send_word(w);
  endtask

  // Drain all results, then let an ignored word finish before touching config
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic mode, input logic [23:0] step);
    cfg_we <= 1'b1;
    cfg_index <= gqi_pkg::REG_MODE;
    cfg_wdata <= {23'd0, mode};
    @(posedge clk);
    cfg_index <= gqi_pkg::REG_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word();
    gqi_pkg::in_word_t w;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    w.opcode = sel < 60 ? gqi_pkg::OP_INTEG : sel < 80 ? gqi_pkg::OP_LOAD_INT :
               sel < 90 ? gqi_pkg::OP_LOAD : gqi_pkg::OP_NONE;
    if ($urandom_range(0, 9) < 6) begin
      w.rate_x = 24'(span(1 << 18)); w.rate_y = 24'(span(1 << 18));
      w.rate_z = 24'(span(1 << 18));
    end else begin
      w.rate_x = 24'($urandom); w.rate_y = 24'($urandom); w.rate_z = 24'($urandom);
    end
    if ($urandom_range(0, 9) < 7) begin
      w.load_w = span(1 << 29); w.load_x = span(1 << 29);
      w.load_y = span(1 << 29); w.load_z = span(1 << 29);
    end else begin
      w.load_w = span(1 << 30); w.load_x = span(1 << 30);
      w.load_y = span(1 << 30); w.load_z = span(1 << 30);
    end
    send_word(w);
  endtask

  // Result side: random stalls, bursts without them, one long hold on request
  initial begin
    int n;
    out_stall <= 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        n = 3000;
        hold_long = 1'b0;
      end else begin
        n = no_gaps ? 0 : $urandom_range(0, 10);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic signed [31:0] one;
    logic signed [31:0] neg1;
    one = gqi_pkg::ONE_Q30;
    neg1 = -gqi_pkg::ONE_Q30;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= gqi_pkg::REG_MODE;
    cfg_wdata <= '0;
    hold_long = 1'b0;
    no_gaps = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: defaults, Euler
    send_fields(gqi_pkg::OP_INTEG, 0, 0, 0, 0, 0, 0, 0);
    send_fields(gqi_pkg::OP_INTEG, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0, 0);
    send_fields(gqi_pkg::OP_INTEG, -24'sh800000, -24'sh800000, -24'sh800000, 0, 0, 0, 0);
    send_fields(gqi_pkg::OP_LOAD, 0, 0, 0, one, 0, 0, 0);
    send_fields(gqi_pkg::OP_LOAD_INT, 24'sh010000, -24'sh020000, 24'sh008000,
                one, one, one, one);
    send_fields(gqi_pkg::OP_LOAD_INT, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF,
                neg1, neg1, neg1, neg1);
    // Zero quaternion with Euler gives zero norm
    send_fields(gqi_pkg::OP_LOAD_INT, 24'sh123456, -24'sh654321, 24'sh0F0F0F, 0, 0, 0, 0);
    send_fields(gqi_pkg::OP_LOAD, -24'sh1, -24'sh1, -24'sh1, 0, 0, 0, 0);
    send_fields(gqi_pkg::OP_NONE, -24'sh1, 24'sh7FFFFF, 0, neg1, one, neg1, one);
    send_fields(gqi_pkg::OP_INTEG, 24'sh000100, 24'sh000200, 24'sh000300, 0, 0, 0, 0);
    send_fields(gqi_pkg::OP_LOAD_INT, 0, 0, 0, 32'sd3, -32'sd5, 32'sd7, 32'sd1);
    settle();

    // Directed: trapezoid at zero step, then largest step both modes
    write_cfg(1'b1, 24'd0);
    send_fields(gqi_pkg::OP_LOAD_INT, 24'sh7FFFFF, 24'sh000001, -24'sh800000, one, 0, 0, 0);
    send_fields(gqi_pkg::OP_INTEG, -24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0, 0);
    send_fields(gqi_pkg::OP_LOAD_INT, 0, 0, 0, 0, 0, 0, 0);
    settle();
    write_cfg(1'b0, 24'hFFFFFF);
    send_fields(gqi_pkg::OP_INTEG, 24'sh7FFFFF, 0, -24'sh800000, 0, 0, 0, 0);
    send_fields(gqi_pkg::OP_LOAD_INT, -24'sh800000, -24'sh800000, 24'sh7FFFFF,
                one, neg1, one, neg1);
    settle();
    write_cfg(1'b1, 24'hFFFFFF);
    send_fields(gqi_pkg::OP_INTEG, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0, 0);
    send_fields(gqi_pkg::OP_LOAD_INT, 24'sh000001, 0, 0, 0, 0, 0, 0);
    send_fields(gqi_pkg::OP_INTEG, -24'sh000001, 0, 0, 0, 0, 0, 0);
    settle();

    // Random phases under varied settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_cfg(1'b0, gqi_pkg::STEP_RESET);
        1: write_cfg(1'b1, gqi_pkg::STEP_RESET);
        2: write_cfg(1'b1, 24'hFFFFFF);
        3: write_cfg(1'b0, 24'd0);
        default: write_cfg(1'($urandom_range(0, 1)), 24'($urandom));
      endcase
      no_gaps = (ph == 4);
      for (int i = 0; i < 200; i++) begin
        // Hold the result side off while words keep coming
        if (ph == 2 && i == 50) hold_long = 1'b1;
        random_word();
      end
      settle();
    end
    no_gaps = 1'b0;

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

### gyro_quaternion_integrator.f
+incdir+hdl
hdl/gqi_pkg.sv
hdl/gqi_datapath.sv
hdl/gqi_ctrl.sv
hdl/gyro_quaternion_integrator.sv
tb/gqi_checker.sv
tb/tb_gyro_quaternion_integrator.sv
